@@ hw/rtl/btsr_pkg.sv @@
// Shared types and constants for the bit-tree sum reduction core.
// Depends on nothing; every other file in hw/rtl imports it.
package btsr_pkg;

	// Tree shape
	localparam int MAX_DEPTH  = 10;
	localparam int LEAF_COUNT = 1 << MAX_DEPTH;
	localparam int HALF_COUNT = LEAF_COUNT / 2;
	localparam int WORD_COUNT = (LEAF_COUNT / 32 > 0) ? LEAF_COUNT / 32 : 1;
	localparam int WORD_AW    = (MAX_DEPTH > 5) ? MAX_DEPTH - 5 : 1;
	localparam int NODE_AW    = MAX_DEPTH;
	localparam int SUM_W      = MAX_DEPTH + 1;

	// Port field widths
	localparam int MODE_W = 2;
	localparam int WIDX_W = 5;
	localparam int WORD_W = 32;
	localparam int NIDX_W = 11;
	localparam int CNT_W  = 11;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 2'd0,
		MODE_REDUCE = 2'd1,
		MODE_READ   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RED_ISSUE,
		ST_RED_WRITE
	} state_t;

	// Node store access for one cycle
	typedef struct packed {
		logic               we;
		logic [NODE_AW-1:0] waddr;
		logic [SUM_W-1:0]   wdata;
		logic [NODE_AW-1:0] raddr_a;
		logic [NODE_AW-1:0] raddr_b;
	} ram_req_t;

endpackage

@@ hw/rtl/btsr_leaf_store.sv @@
// Leaf bitfield of the tree, one 32-bit word per entry, cleared by reset.
// Depends on btsr_pkg.
module btsr_leaf_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [btsr_pkg::WORD_AW-1:0]  waddr,
	input  logic [btsr_pkg::WORD_W-1:0]   wdata,
	input  logic [btsr_pkg::WORD_AW-1:0]  raddr,
	output logic [btsr_pkg::WORD_W-1:0]   rdata
);
	import btsr_pkg::*;

	logic [WORD_W-1:0] words_q [WORD_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				words_q[i] <= '0;
			end
		end else if (we) begin
			words_q[waddr] <= wdata;
		end
	end

	assign rdata = words_q[raddr];

endmodule

@@ hw/rtl/btsr_node_ram.sv @@
// Node count store: one write port, two read ports with registered data.
// Depends on btsr_pkg for the request struct and sizes.
module btsr_node_ram (
	input  logic                        clk,
	input  btsr_pkg::ram_req_t          req,
	output logic [btsr_pkg::SUM_W-1:0]  rdata_a,
	output logic [btsr_pkg::SUM_W-1:0]  rdata_b
);
	import btsr_pkg::*;

	logic [SUM_W-1:0] mem [LEAF_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

@@ hw/rtl/bit_tree_sum_reduction_core.sv @@
// Top level of the bit-tree sum reduction core: sequencer, shared adder, result register.
// Depends on btsr_pkg, btsr_leaf_store and btsr_node_ram.
//
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with done high, which the receiver
// must take as it comes. A leaf word write, an unused mode, a read of index
// zero, a leaf read, a read past the tree or any read before the first
// reduction returns its result in the cycle after acceptance, one command per
// cycle. Other internal node reads pass through ST_READ for the node store's
// registered read. A reduction walks every internal node from the last down to
// the root through one shared adder and one node store write port: a node above
// the leaves is added from its leaf word and written in ST_RED_ISSUE, every other
// node reads both children in ST_RED_ISSUE, then adds and writes in ST_RED_WRITE;
// done follows in the cycle after the root is written. After reset no reduction
// has yet run and every internal node reads as zero; there is no clearing pass.
module bit_tree_sum_reduction_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [btsr_pkg::MODE_W-1:0] mode,
	input  logic [btsr_pkg::WIDX_W-1:0] word_index,
	input  logic [btsr_pkg::WORD_W-1:0] leaf_word,
	input  logic [btsr_pkg::NIDX_W-1:0] node_index,
	output logic                        busy,
	output logic                        done,
	output logic [btsr_pkg::CNT_W-1:0]  node_count,
	output logic                        index_error
);
	import btsr_pkg::*;

	state_t             state_q, state_d;
	logic [NODE_AW-1:0] node_q, node_d;
	logic               reduced_q, reduced_d;
	logic               done_q, done_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               err_q, err_d;

	ram_req_t           ram_req;
	logic [SUM_W-1:0]   ram_rdata_a, ram_rdata_b;

	logic               leaf_we;
	logic [WORD_AW-1:0] leaf_raddr;
	logic [WORD_W-1:0]  leaf_rword;

	logic [31:0]        nidx_ext;
	logic [NODE_AW-1:0] leaf_idx;
	logic [NODE_AW-1:0] pair_idx;
	logic               leaf_level;
	logic               widx_ok;
	logic [SUM_W-1:0]   add_a, add_b, add_sum;

	btsr_leaf_store u_leaf (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (leaf_we),
		.waddr  (WORD_AW'(word_index)),
		.wdata  (leaf_word),
		.raddr  (leaf_raddr),
		.rdata  (leaf_rword)
	);

	btsr_node_ram u_nodes (
		.clk     (clk),
		.req     (ram_req),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	assign nidx_ext   = 32'(node_index);
	assign leaf_idx   = NODE_AW'(nidx_ext - 32'(LEAF_COUNT));
	assign pair_idx   = NODE_AW'(node_q - NODE_AW'(HALF_COUNT));
	assign leaf_level = node_q[NODE_AW-1];
	assign widx_ok    = 32'(word_index) < 32'(WORD_COUNT);

	// Sixteen leaf pairs per word: bottom level reads the word of the pair
	assign leaf_raddr = (state_q == ST_RED_ISSUE) ? WORD_AW'(pair_idx >> 4)
	                                              : WORD_AW'(leaf_idx >> 5);

	// Shared adder: two leaf bits on the bottom level, two child counts above it
	assign add_a   = leaf_level ? SUM_W'(leaf_rword[{pair_idx[3:0], 1'b0}]) : ram_rdata_a;
	assign add_b   = leaf_level ? SUM_W'(leaf_rword[{pair_idx[3:0], 1'b1}]) : ram_rdata_b;
	assign add_sum = add_a + add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			node_q    <= '0;
			reduced_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
			err_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			node_q    <= node_d;
			reduced_q <= reduced_d;
			done_q    <= done_d;
			count_q   <= count_d;
			err_q     <= err_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		node_d          = node_q;
		reduced_d       = reduced_q;
		done_d          = 1'b0;
		count_d         = '0;
		err_d           = 1'b0;
		leaf_we         = 1'b0;
		ram_req.we      = 1'b0;
		ram_req.waddr   = node_q;
		ram_req.wdata   = add_sum;
		ram_req.raddr_a = NODE_AW'(node_index);
		ram_req.raddr_b = NODE_AW'(node_index);

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode_t'(mode))
						MODE_WRITE: begin
							leaf_we = widx_ok;
							done_d  = 1'b1;
						end
						MODE_REDUCE: begin
							node_d    = NODE_AW'(LEAF_COUNT - 1);
							reduced_d = 1'b1;
							state_d   = ST_RED_ISSUE;
						end
						MODE_READ: begin
							if (node_index == '0) begin
								err_d  = 1'b1;
								done_d = 1'b1;
							end else if (nidx_ext < 32'(LEAF_COUNT)) begin
								// Before the first reduction every node reads as zero
								if (reduced_q) begin
									state_d = ST_READ;
								end else begin
									done_d = 1'b1;
								end
							end else if (nidx_ext < 32'(2 * LEAF_COUNT)) begin
								count_d = CNT_W'(leaf_rword[leaf_idx[4:0]]);
								done_d  = 1'b1;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				count_d = CNT_W'(ram_rdata_a);
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RED_ISSUE: begin
				if (leaf_level) begin
					ram_req.we = 1'b1;
					node_d     = node_q - NODE_AW'(1);
				end else begin
					ram_req.raddr_a = {node_q[NODE_AW-2:0], 1'b0};
					ram_req.raddr_b = {node_q[NODE_AW-2:0], 1'b1};
					state_d         = ST_RED_WRITE;
				end
			end
			ST_RED_WRITE: begin
				ram_req.we = 1'b1;
				if (node_q == NODE_AW'(1)) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					node_d  = node_q - NODE_AW'(1);
					state_d = ST_RED_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign node_count  = count_q;
	assign index_error = err_q;

`ifndef SYNTH
	a_err_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		index_error |-> done && node_count == '0)
		else $error("index error reported with a count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result shown while sequencer still active");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> done)
		else $error("node read gave no result");

	a_fast_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode != MODE_READ && mode != MODE_REDUCE |=> done)
		else $error("leaf write gave no result in the next cycle");

	a_red_node_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RED_WRITE && node_q != NODE_AW'(1) |=> node_q == $past(node_q) - NODE_AW'(1))
		else $error("reduction skipped a node");
`endif

endmodule

@@ tb/sv/tb_bit_tree_sum_reduction_core.sv @@
`timescale 1ns / 1ps
// Testbench for bit_tree_sum_reduction_core: leaf word writes, tree reductions and node reads.
// Depends on btsr_pkg and the core; it keeps its own copy of the leaf and node stores.
module tb_bit_tree_sum_reduction_core;
	import btsr_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WIDX_W-1:0] widx;
		logic [WORD_W-1:0] word;
		logic [NIDX_W-1:0] nidx;
	} tree_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             err;
	} node_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic [MODE_W-1:0]   mode;
	logic [WIDX_W-1:0]   word_index;
	logic [WORD_W-1:0]   leaf_word;
	logic [NIDX_W-1:0]   node_index;
	logic                busy;
	logic                done;
	logic [CNT_W-1:0]    node_count;
	logic                index_error;

	// Shadow of the core's stores
	logic [WORD_W-1:0]   tree_leaves [WORD_COUNT];
	logic [CNT_W-1:0]    tree_counts [LEAF_COUNT];

	node_result_t        expected_results [$];
	node_result_t        want_result;
	int                  fail_count;
	int                  items_sent;
	int                  burst_left;

	bit_tree_sum_reduction_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.word_index  (word_index),
		.leaf_word   (leaf_word),
		.node_index  (node_index),
		.busy        (busy),
		.done        (done),
		.node_count  (node_count),
		.index_error (index_error)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic leaf_bit(input int unsigned leaf);
		return tree_leaves[(leaf >> 5) % WORD_COUNT][leaf & 31];
	endfunction

	// Apply one word to the shadow stores and work out the result it gives
	function automatic node_result_t update_tree(input tree_cmd_t c);
		node_result_t r;
		r = '0;
		case (c.mode)
			MODE_WRITE: begin
				if (c.widx < WORD_COUNT)
					tree_leaves[c.widx] = c.word;
			end
			MODE_REDUCE: begin
				// Bottom-up: the lowest internal level counts leaf pairs directly
				for (int n = LEAF_COUNT - 1; n >= 1; n--) begin
					if (n >= HALF_COUNT)
						tree_counts[n] = CNT_W'(leaf_bit(2 * n - LEAF_COUNT))
							+ CNT_W'(leaf_bit(2 * n + 1 - LEAF_COUNT));
					else
						tree_counts[n] = tree_counts[2 * n] + tree_counts[2 * n + 1];
				end
			end
			MODE_READ: begin
				if (c.nidx == 0)
					r.err = 1'b1;
				else if (c.nidx < LEAF_COUNT)
					r.count = tree_counts[c.nidx];
				else if (c.nidx < 2 * LEAF_COUNT)
					r.count = CNT_W'(leaf_bit(c.nidx - LEAF_COUNT));
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic tree_cmd_t rand_cmd();
		tree_cmd_t c;
		c.mode = MODE_W'($urandom);
		c.widx = WIDX_W'($urandom);
		c.word = $urandom;
		c.nidx = NIDX_W'($urandom);
		return c;
	endfunction

	function automatic tree_cmd_t cmd_write(input int unsigned widx, input logic [WORD_W-1:0] word);
		tree_cmd_t c;
		c = rand_cmd();
		c.mode = MODE_WRITE;
		c.widx = WIDX_W'(widx);
		c.word = word;
		return c;
	endfunction

	function automatic tree_cmd_t cmd_reduce();
		tree_cmd_t c;
		c = rand_cmd();
		c.mode = MODE_REDUCE;
		return c;
	endfunction

	function automatic tree_cmd_t cmd_read(input int unsigned nidx);
		tree_cmd_t c;
		c = rand_cmd();
		c.mode = MODE_READ;
		c.nidx = NIDX_W'(nidx);
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] rand_leaf_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_node_index();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2, 3, 4: return $urandom_range(1, LEAF_COUNT - 1);
			5, 6, 7: return $urandom_range(LEAF_COUNT, 2 * LEAF_COUNT - 1);
			8: return $urandom_range(1, 31);
			default: return $urandom_range(0, 2047);
		endcase
	endfunction

	// Drop start for a random gap at the end of each burst
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic send_word(input tree_cmd_t c);
		@(negedge clk);
		start      <= 1'b1;
		mode       <= c.mode;
		word_index <= c.widx;
		leaf_word  <= c.word;
		node_index <= c.nidx;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(update_tree(c));
		if (c.mode != MODE_UNUSED)
			items_sent++;
		pace_sender();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected result: count %0d error %0d", node_count, index_error);
				fail_count++;
			end else begin
				want_result = expected_results.pop_front();
				if (node_count !== want_result.count || index_error !== want_result.err) begin
					if (fail_count < MAX_REPORTS)
						$display("mismatch: expected count %0d error %0d, got count %0d error %0d",
							want_result.count, want_result.err, node_count, index_error);
					fail_count++;
				end
			end
		end
	end

	// Reads before any reduction see zero sums at internal nodes; index zero and leaf reads are mixed in
	task automatic test_stale_reads();
		send_word(cmd_read(1));
		send_word(cmd_read(0));
		send_word(cmd_read(LEAF_COUNT));
		send_word(cmd_read(2047));
		send_word(cmd_read(HALF_COUNT));
		send_word(cmd_write(31, $urandom));
		send_word(cmd_read(LEAF_COUNT - 1));
	endtask

	task automatic test_directed_tree();
		tree_cmd_t c;
		c = rand_cmd();
		c.mode = MODE_UNUSED;
		send_word(c);
		send_word(cmd_write(0, '1));
		send_word(cmd_write(31, 32'h8000_0001));
		send_word(cmd_write(5, 32'hA5A5_5A5A));
		send_word(cmd_reduce());
		send_word(cmd_read(1));
		send_word(cmd_read(2));
		send_word(cmd_read(3));
		send_word(cmd_read(32));
		send_word(cmd_read(63));
		send_word(cmd_read(HALF_COUNT));
		send_word(cmd_read(LEAF_COUNT - 1));
		send_word(cmd_read(LEAF_COUNT));
		send_word(cmd_read(2047));
		// Leaf changes show at once; sums stay stale until the next reduction
		send_word(cmd_write(0, '0));
		send_word(cmd_read(32));
		send_word(cmd_read(LEAF_COUNT + 1));
		send_word(cmd_reduce());
		send_word(cmd_read(32));
	endtask

	// Every leaf set: the root reaches its largest count
	task automatic test_full_tree();
		for (int w = 0; w < WORD_COUNT; w++)
			send_word(cmd_write(w, '1));
		send_word(cmd_reduce());
		send_word(cmd_read(1));
		send_word(cmd_read(3));
		send_word(cmd_read(LEAF_COUNT - 1));
		send_word(cmd_read(2047));
	endtask

	task automatic test_random_sequences();
		tree_cmd_t c;
		int        n;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(cmd_write($urandom_range(0, 31), rand_leaf_word()));
				send_word(cmd_reduce());
				n = $urandom_range(2, 10);
				repeat (n) send_word(cmd_read(pick_node_index()));
			end else begin
				c = rand_cmd();
				// Keep reductions rare in the noise, since each one walks the whole tree
				if (c.mode == MODE_REDUCE && $urandom_range(0, 3) != 0)
					c.mode = MODE_READ;
				send_word(c);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		mode       = '0;
		word_index = '0;
		leaf_word  = '0;
		node_index = '0;
		fail_count = 0;
		items_sent = 0;
		burst_left = 1;
		for (int w = 0; w < WORD_COUNT; w++)
			tree_leaves[w] = '0;
		for (int n = 0; n < LEAF_COUNT; n++)
			tree_counts[n] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stale_reads();
		test_directed_tree();
		test_full_tree();
		test_random_sequences();

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS bit_tree_sum_reduction_core");
		else
			$display("FAIL bit_tree_sum_reduction_core");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL bit_tree_sum_reduction_core");
		$finish;
	end

endmodule
